[hw/rtl/sto_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sto_pkg
// Shared types and constants of the sorted timeout list: sizes, request
// codes, item structs and the entry memory command.
// ----------------------------------------------------------------------------
package sto_pkg;

	localparam int MAX_SLOTS = 1024;
	localparam int DEPTH     = MAX_SLOTS + 1;
	localparam int IDX_W     = $clog2(DEPTH);
	localparam int SLOT_W    = 10;
	localparam int ID_W      = 32;
	localparam int TIME_W    = 32;
	localparam int OFS_W     = 24;

	localparam logic REQ_RESET = 1'b0;
	localparam logic REQ_POP   = 1'b1;

	typedef logic [IDX_W-1:0] idx_t;

	typedef struct packed {
		logic              req_type;
		logic [ID_W-1:0]   entity_id;
		logic [SLOT_W-1:0] slot;
		logic [OFS_W-1:0]  time_offset;
		logic [OFS_W-1:0]  pop_timeout;
		logic [TIME_W-1:0] now;
	} req_t;

	typedef struct packed {
		logic [ID_W-1:0] popped_id;
		logic            found;
	} rsp_t;

	// One list entry; next/prev value 0 names the sentinel.
	typedef struct packed {
		idx_t              next_link;
		idx_t              prev_link;
		logic              linked;
		logic [TIME_W-1:0] deadline;
		logic [OFS_W-1:0]  stored_offset;
		logic [ID_W-1:0]   owner_id;
	} entry_t;

	// Single-port access: either a read or a masked write per command.
	typedef struct packed {
		idx_t addr;
		logic rd;
		logic wr_next;
		logic wr_prev;
		logic wr_body;
	} mem_cmd_t;

endpackage

[hw/rtl/sto_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sto_mem
// Entry memory: single port, registered read, write enables per field group
// (next link, prev link, body).
// ----------------------------------------------------------------------------
module sto_mem
	import sto_pkg::*;
(
	input  logic     clk,
	input  mem_cmd_t cmd,
	input  entry_t   wdata,
	output entry_t   rdata
);

	idx_t              next_mem   [DEPTH];
	idx_t              prev_mem   [DEPTH];
	logic              linked_mem [DEPTH];
	logic [TIME_W-1:0] dl_mem     [DEPTH];
	logic [OFS_W-1:0]  ofs_mem    [DEPTH];
	logic [ID_W-1:0]   owner_mem  [DEPTH];

	always_ff @(posedge clk) begin
		if (cmd.wr_next) begin
			next_mem[cmd.addr] <= wdata.next_link;
		end
		if (cmd.wr_prev) begin
			prev_mem[cmd.addr] <= wdata.prev_link;
		end
		if (cmd.wr_body) begin
			linked_mem[cmd.addr] <= wdata.linked;
			dl_mem[cmd.addr]     <= wdata.deadline;
			ofs_mem[cmd.addr]    <= wdata.stored_offset;
			owner_mem[cmd.addr]  <= wdata.owner_id;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rdata.next_link     <= next_mem[cmd.addr];
			rdata.prev_link     <= prev_mem[cmd.addr];
			rdata.linked        <= linked_mem[cmd.addr];
			rdata.deadline      <= dl_mem[cmd.addr];
			rdata.stored_offset <= ofs_mem[cmd.addr];
			rdata.owner_id      <= owner_mem[cmd.addr];
		end
	end

endmodule

[hw/rtl/sto_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sto_ctrl
// Sequencer of the sorted timeout list: holds head and tail of the list,
// clears the entry memory after reset, and runs unlink, tail walk, insert
// and pop as read-modify-write steps on the entry memory.
// ----------------------------------------------------------------------------
module sto_ctrl
	import sto_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  req_t     req,
	output logic     busy,
	output logic     done,
	output rsp_t     rsp,
	output mem_cmd_t cmd,
	output entry_t   wdata,
	input  entry_t   rdata
);

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_E_RD,
		ST_UNL_N,
		ST_UNL_P,
		ST_PLACE,
		ST_WALK,
		ST_INS_E,
		ST_INS_N,
		ST_INS_A,
		ST_POP_RD,
		ST_POP_N,
		ST_POP_H
	} state_t;

	state_t            state_q;
	idx_t              head_q;
	idx_t              tail_q;
	idx_t              clr_q;
	idx_t              e_q;
	idx_t              n_q;
	idx_t              p_q;
	idx_t              a_q;
	idx_t              nx_q;
	logic              walk_q;
	logic [OFS_W-1:0]  off_q;
	logic [TIME_W-1:0] t_q;
	req_t              req_q;
	logic              done_q;
	rsp_t              rsp_q;

	logic              slot_ok;
	idx_t              slot_e;
	logic [OFS_W-1:0]  off_new;
	logic [TIME_W:0]   dl_sum;
	logic [TIME_W-1:0] dl_sat;
	logic [TIME_W:0]   exp_sum;
	logic              expired;
	logic              walk_more;

	assign slot_ok = 32'(req.slot) < 32'(MAX_SLOTS);
	assign slot_e  = idx_t'(req.slot) + idx_t'(1);

	// new delay and saturated deadline from the entry just read
	assign off_new = (req_q.time_offset != '0) ? req_q.time_offset : rdata.stored_offset;
	assign dl_sum  = {1'b0, req_q.now} + {{(TIME_W + 1 - OFS_W){1'b0}}, off_new};
	assign dl_sat  = dl_sum[TIME_W] ? '1 : dl_sum[TIME_W-1:0];

	assign exp_sum = {1'b0, rdata.deadline} + {{(TIME_W + 1 - OFS_W){1'b0}}, req_q.pop_timeout};
	assign expired = exp_sum <= {1'b0, req_q.now};

	assign walk_more = rdata.deadline > t_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			head_q  <= '0;
			tail_q  <= '0;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + idx_t'(1);
					if (clr_q == idx_t'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						req_q <= req;
						rsp_q <= '0;
						if (req.req_type == REQ_POP) begin
							e_q <= head_q;
							if (head_q == '0) begin
								done_q <= 1'b1;
							end else begin
								state_q <= ST_POP_RD;
							end
						end else begin
							e_q <= slot_e;
							if (req.entity_id == '0 || !slot_ok) begin
								done_q <= 1'b1;
							end else begin
								state_q <= ST_E_RD;
							end
						end
					end
				end
				ST_E_RD: begin
					off_q  <= off_new;
					walk_q <= off_new != '0;
					t_q    <= (off_new != '0) ? dl_sat : req_q.now;
					n_q    <= rdata.next_link;
					p_q    <= rdata.prev_link;
					state_q <= rdata.linked ? ST_UNL_N : ST_PLACE;
				end
				ST_UNL_N: begin
					if (n_q == '0) begin
						tail_q <= p_q;
					end
					state_q <= ST_UNL_P;
				end
				ST_UNL_P: begin
					if (p_q == '0) begin
						head_q <= n_q;
					end
					state_q <= ST_PLACE;
				end
				ST_PLACE: begin
					a_q  <= tail_q;
					nx_q <= '0;
					state_q <= (walk_q && tail_q != '0) ? ST_WALK : ST_INS_E;
				end
				ST_WALK: begin
					if (walk_more) begin
						a_q <= rdata.prev_link;
						if (rdata.prev_link == '0) begin
							nx_q    <= head_q;
							state_q <= ST_INS_E;
						end
					end else begin
						nx_q    <= rdata.next_link;
						state_q <= ST_INS_E;
					end
				end
				ST_INS_E: begin
					if (nx_q == '0) begin
						tail_q <= e_q;
					end
					if (a_q == '0) begin
						head_q <= e_q;
					end
					state_q <= ST_INS_N;
				end
				ST_INS_N: begin
					state_q <= ST_INS_A;
				end
				ST_INS_A: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_POP_RD: begin
					if (expired) begin
						n_q    <= rdata.next_link;
						head_q <= rdata.next_link;
						if (rdata.next_link == '0) begin
							tail_q <= '0;
						end
						rsp_q.popped_id <= rdata.owner_id;
						rsp_q.found     <= 1'b1;
						state_q <= ST_POP_N;
					end else begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_POP_N: begin
					state_q <= ST_POP_H;
				end
				ST_POP_H: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// memory command for the current step
	always_comb begin
		cmd   = '0;
		wdata = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.addr    = clr_q;
				cmd.wr_next = 1'b1;
				cmd.wr_prev = 1'b1;
				cmd.wr_body = 1'b1;
			end
			ST_IDLE: begin
				if (start) begin
					if (req.req_type == REQ_POP) begin
						cmd.addr = head_q;
						cmd.rd   = head_q != '0;
					end else begin
						cmd.addr = slot_e;
						cmd.rd   = req.entity_id != '0 && slot_ok;
					end
				end
			end
			ST_UNL_N: begin
				cmd.addr        = n_q;
				cmd.wr_prev     = n_q != '0;
				wdata.prev_link = p_q;
			end
			ST_UNL_P: begin
				cmd.addr        = p_q;
				cmd.wr_next     = p_q != '0;
				wdata.next_link = n_q;
			end
			ST_PLACE: begin
				cmd.addr = tail_q;
				cmd.rd   = walk_q && tail_q != '0;
			end
			ST_WALK: begin
				cmd.addr = rdata.prev_link;
				cmd.rd   = walk_more && rdata.prev_link != '0;
			end
			ST_INS_E: begin
				cmd.addr            = e_q;
				cmd.wr_next         = 1'b1;
				cmd.wr_prev         = 1'b1;
				cmd.wr_body         = 1'b1;
				wdata.next_link     = nx_q;
				wdata.prev_link     = a_q;
				wdata.linked        = 1'b1;
				wdata.deadline      = t_q;
				wdata.stored_offset = off_q;
				wdata.owner_id      = req_q.entity_id;
			end
			ST_INS_N: begin
				cmd.addr        = nx_q;
				cmd.wr_prev     = nx_q != '0;
				wdata.prev_link = e_q;
			end
			ST_INS_A: begin
				cmd.addr        = a_q;
				cmd.wr_next     = a_q != '0;
				wdata.next_link = e_q;
			end
			ST_POP_N: begin
				cmd.addr    = n_q;
				cmd.wr_prev = n_q != '0;
			end
			ST_POP_H: begin
				cmd.addr    = e_q;
				cmd.wr_next = 1'b1;
				cmd.wr_prev = 1'b1;
				cmd.wr_body = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	assign busy = state_q != ST_IDLE;
	assign done = done_q;
	assign rsp  = rsp_q;

	// empty list means both ends point at the sentinel
	a_ends_agree: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> ((head_q == '0) == (tail_q == '0)))
		else $error("head and tail disagree on empty list");

	a_port_excl: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd |-> !(cmd.wr_next || cmd.wr_prev || cmd.wr_body))
		else $error("read and write issued in the same cycle");

	a_addr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.rd || cmd.wr_next || cmd.wr_prev || cmd.wr_body) |->
		(32'(cmd.addr) < 32'(DEPTH)))
		else $error("entry address out of range");

	a_walk_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (a_q != '0 && $past(cmd.rd)))
		else $error("walk step without a pending entry read");

	a_found_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && rsp_q.found) |-> (req_q.req_type == REQ_POP))
		else $error("found raised by a reset request");

endmodule

[hw/rtl/sorted_timeout_list_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_timeout_list_top
// Deadline queue kept as a doubly linked list, sorted by expiry time, in a
// slot-indexed entry memory; sentinel links are held as head/tail registers.
// ----------------------------------------------------------------------------
//
//  channel   signals            handshake
//  --------  -----------------  ---------------------------------------------
//  request   start, req, busy   item taken at a clock edge with start & !busy
//  result    done, rsp          one item per request, valid for one cycle
//
//  A pop of an empty list or an ignored reschedule answers straight from
//  idle. Other pops read the head; an expired head is taken off, the next
//  entry's back link is cleared and the entry is wiped. A reschedule reads
//  its entry, unlinks it if linked and, with a nonzero delay, walks back from
//  the tail, one entry read per step (the stopping entry included), then
//  writes the entry and its neighbours. Reset: after arst_n rises, busy stays
//  high while the entry memory is swept clear, one entry per cycle.
//  The result side has no back pressure; done is a one-cycle strobe.
//
module sorted_timeout_list_top
	import sto_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t req,
	output logic busy,
	output logic done,
	output rsp_t rsp
);

	// control path to the entry memory
	mem_cmd_t cmd;
	entry_t   wdata;
	entry_t   rdata;

	// sequencer: unlink, walk, insert, pop and the clearing sweep
	sto_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (busy),
		.done   (done),
		.rsp    (rsp),
		.cmd    (cmd),
		.wdata  (wdata),
		.rdata  (rdata)
	);

	// entry memory: links, flag, deadline, delay and owner per slot
	sto_mem u_mem (
		.clk   (clk),
		.cmd   (cmd),
		.wdata (wdata),
		.rdata (rdata)
	);

endmodule

[tb/sv/sorted_timeout_list_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_timeout_list_top_tb
// Self-checking bench for the deadline queue. A table of directed items walks
// the edge cases, then random reschedule/pop traffic runs against a local
// linked-list predictor; every result strobe is compared with the oldest
// expected result, hand-typed or predicted.
// ----------------------------------------------------------------------------
module sorted_timeout_list_top_tb;
	import sto_pkg::*;

	localparam int CYCLE_LIMIT   = 4_000_000;
	localparam int RANDOM_ITEMS  = 700;
	localparam int SETTLE_CYCLES = 64;
	localparam int POOL_SLOTS    = 16;
	localparam int MAX_REPORTS   = 10;

	logic clk;
	logic arst_n;
	logic start;
	req_t req;
	logic busy;
	logic done;
	rsp_t rsp;

	sorted_timeout_list_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (busy),
		.done   (done),
		.rsp    (rsp)
	);

	// One directed item; known marks rows whose result is typed in by hand.
	typedef struct {
		req_t r;
		bit   known;
		rsp_t hand_rsp;
	} dir_row_t;

	// Shadow of the entry memory. Entry 0 is the sentinel: fwd[0] is the head,
	// bwd[0] the tail. Slot s lives at entry s + 1.
	idx_t              fwd[DEPTH];
	idx_t              bwd[DEPTH];
	bit                on_list[DEPTH];
	logic [TIME_W-1:0] due[DEPTH];
	logic [OFS_W-1:0]  delay[DEPTH];
	logic [ID_W-1:0]   owner[DEPTH];

	rsp_t     pending_rsp[$];
	dir_row_t dir_rows[$];

	int unsigned       cycle_count  = 0;
	int unsigned       mismatches   = 0;
	int unsigned       results_seen = 0;
	int unsigned       n_resched    = 0;
	int unsigned       n_pops       = 0;
	int unsigned       n_expired    = 0;
	int unsigned       n_ignored    = 0;
	logic [TIME_W-1:0] clock_base   = '0;

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------

	// Unlink an entry and mark it free.
	function automatic void drop_entry(idx_t e);
		idx_t n;
		idx_t p;
		n = fwd[e];
		p = bwd[e];
		bwd[n] = p;
		fwd[p] = n;
		fwd[e] = '0;
		bwd[e] = '0;
		on_list[e] = 1'b0;
	endfunction

	// Reschedule: relink the entry at its new deadline. A zero stored delay
	// appends at the tail with deadline now; otherwise walk back from the tail
	// past every entry due strictly later, so equal deadlines keep arrival order.
	function automatic void schedule_entry(req_t r);
		idx_t              e;
		idx_t              after;
		logic [TIME_W:0]   sum;
		logic [TIME_W-1:0] t;
		if (r.entity_id == '0 || int'(r.slot) >= MAX_SLOTS)
			return;
		e = idx_t'(r.slot) + idx_t'(1);
		if (on_list[e])
			drop_entry(e);
		t = r.now;
		after = bwd[0];
		if (r.time_offset != '0)
			delay[e] = r.time_offset;
		if (delay[e] != '0) begin
			sum = {1'b0, r.now} + (TIME_W+1)'(delay[e]);
			t = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
			while (after != '0 && due[after] > t)
				after = bwd[after];
		end
		fwd[e] = fwd[after];
		bwd[e] = after;
		owner[e] = r.entity_id;
		due[e] = t;
		on_list[e] = 1'b1;
		bwd[fwd[after]] = e;
		fwd[after] = e;
	endfunction

	// Pop: remove the head only if its deadline plus the timeout, without
	// wrap, is not past now. The popped entry forgets its stored delay.
	function automatic rsp_t pop_expired_head(req_t r);
		idx_t h;
		rsp_t res;
		res = '0;
		h = fwd[0];
		if (h == '0)
			return res;
		if ({1'b0, due[h]} + (TIME_W+1)'(r.pop_timeout) > {1'b0, r.now})
			return res;
		drop_entry(h);
		delay[h] = '0;
		res.popped_id = owner[h];
		res.found = 1'b1;
		return res;
	endfunction

	function automatic rsp_t predict_response(req_t r);
		if (r.req_type == REQ_POP)
			return pop_expired_head(r);
		schedule_entry(r);
		return '0;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	function automatic req_t mk_req(logic kind, logic [ID_W-1:0] id,
			logic [SLOT_W-1:0] slot, logic [OFS_W-1:0] ofs,
			logic [OFS_W-1:0] tmo, logic [TIME_W-1:0] now);
		req_t r;
		r.req_type    = kind;
		r.entity_id   = id;
		r.slot        = slot;
		r.time_offset = ofs;
		r.pop_timeout = tmo;
		r.now         = now;
		return r;
	endfunction

	function automatic void add_row(req_t r, bit known, logic [ID_W-1:0] id, logic hit);
		dir_row_t row;
		row.r = r;
		row.known = known;
		row.hand_rsp.popped_id = id;
		row.hand_rsp.found = hit;
		dir_rows.push_back(row);
	endfunction

	// Drive one item: idle for the given gap, then hold start until the block
	// takes the item. Entered and left at a falling edge; start stays high
	// when the next item follows with no gap.
	task automatic issue_item(req_t r, int unsigned gap, bit known, rsp_t hand_rsp);
		rsp_t predicted;
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy);
		predicted = predict_response(r);
		pending_rsp.push_back(known ? hand_rsp : predicted);
		if (r.req_type == REQ_POP) begin
			n_pops++;
			if (predicted.found)
				n_expired++;
		end else if (r.entity_id == '0) begin
			n_ignored++;
		end else begin
			n_resched++;
		end
		@(negedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Clock, cycle counter, watchdog
	// ------------------------------------------------------------------------

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	// Abort a hung run: a lost result or a stuck busy ends up here.
	initial begin : watchdog
		wait (cycle_count >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d results still pending",
			cycle_count, pending_rsp.size());
		$display("RESULT: ERROR");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Result checker: match each strobe against the oldest expectation
	// ------------------------------------------------------------------------

	always @(posedge clk) begin : check_results
		rsp_t want;
		if (arst_n && done) begin
			results_seen++;
			if (pending_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("cycle %0d: unexpected result id %h found %b",
						cycle_count, rsp.popped_id, rsp.found);
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.popped_id !== want.popped_id || rsp.found !== want.found) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("cycle %0d: expected id %h found %b, got id %h found %b",
							cycle_count, want.popped_id, want.found,
							rsp.popped_id, rsp.found);
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------

	initial begin : stimulus
		req_t        r;
		int unsigned gap;
		int unsigned counted;
		int unsigned chunk_left;
		int unsigned pick;
		int unsigned sel;
		bit          quiet;

		// Hold every input at a known value and clear the shadow memory.
		start  = 1'b0;
		req    = '0;
		arst_n = 1'b0;
		for (int i = 0; i < DEPTH; i++) begin
			fwd[i] = '0;
			bwd[i] = '0;
			on_list[i] = 1'b0;
			due[i] = '0;
			delay[i] = '0;
			owner[i] = '0;
		end

		// Directed table. Reschedules always answer 0/0, so the early reschedule
		// rows and the simple pops carry a hand-typed result; the rest use the predictor.
		// pop of an empty list, then an ignored id-zero reschedule
		add_row(mk_req(REQ_POP, '0, '0, '0, '0, '0), 1, '0, 0);
		add_row(mk_req(REQ_RESET, '0, 10'd5, 24'h10, '0, 32'd50), 1, '0, 0);
		// pop with every field at its top value, list still empty
		add_row(mk_req(REQ_POP, '1, '1, '1, '1, '1), 1, '0, 0);
		// zero delay appends at the tail with deadline now
		add_row(mk_req(REQ_RESET, '1, '1, '0, '1, 32'd100), 1, '0, 0);
		// head not yet due, then due exactly at now
		add_row(mk_req(REQ_POP, '0, '0, '0, '0, 32'd99), 1, '0, 0);
		add_row(mk_req(REQ_POP, '0, '0, '0, '0, 32'd100), 1, '1, 1);
		// deadline saturates; a smaller one walks back in front of it
		add_row(mk_req(REQ_RESET, 32'd1, 10'd0, '1, '0, '1), 1, '0, 0);
		add_row(mk_req(REQ_RESET, 32'd2, 10'd1, 24'd1, '0, 32'hFFFF_FFF0), 1, '0, 0);
		add_row(mk_req(REQ_RESET, 32'd3, 10'd2, '0, '0, 32'd5), 1, '0, 0);
		// a huge timeout must not wrap the expiry sum
		add_row(mk_req(REQ_POP, '0, '0, '0, '1, '0), 1, '0, 0);
		add_row(mk_req(REQ_POP, '0, '0, '0, '0, '1), 1, 32'd2, 1);
		// popped slot lost its delay; linked slot keeps its delay
		add_row(mk_req(REQ_RESET, 32'd4, 10'd1, '0, '0, 32'd10), 0, '0, 0);
		add_row(mk_req(REQ_RESET, 32'd5, 10'd0, '0, '0, 32'd20), 0, '0, 0);
		// equal deadlines keep arrival order, relink of a linked slot
		add_row(mk_req(REQ_RESET, 32'd6, 10'd3, 24'd7, '0, 32'd20), 0, '0, 0);
		add_row(mk_req(REQ_RESET, 32'd7, 10'd4, 24'd7, '0, 32'd20), 0, '0, 0);
		add_row(mk_req(REQ_RESET, 32'd8, 10'd3, '0, '0, 32'd20), 0, '0, 0);
		add_row(mk_req(REQ_RESET, 32'h5A5A_5A5A, 10'h2AA, 24'h55_5555, 24'hAA_AAAA,
			32'hA5A5_A5A5), 0, '0, 0);
		// drain everything, then one more pop on the empty list
		repeat (6)
			add_row(mk_req(REQ_POP, '0, '0, '0, '0, '1), 0, '0, 0);
		add_row(mk_req(REQ_POP, '0, '0, '0, '0, '1), 1, '0, 0);

		// Hold reset, then release it at a falling edge.
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// The block sweeps its memory first; issue_item waits on busy.
		foreach (dir_rows[i])
			issue_item(dir_rows[i].r, $urandom_range(0, 3), dir_rows[i].known,
				dir_rows[i].hand_rsp);

		// Random traffic in chunks: some chunks run back to back, others idle
		// at random. The timer mostly creeps forward, sometimes jumps,
		// sometimes sits just below the wrap point.
		counted = 0;
		chunk_left = 0;
		quiet = 1'b0;
		while (counted < RANDOM_ITEMS) begin
			if (chunk_left == 0) begin
				chunk_left = $urandom_range(20, 60);
				quiet = ($urandom_range(0, 3) == 0);
				if ($urandom_range(0, 7) == 0)
					clock_base = 32'hFFFF_FF00 | TIME_W'($urandom_range(0, 255));
				else if ($urandom_range(0, 4) == 0)
					clock_base = $urandom();
			end
			chunk_left--;
			clock_base += TIME_W'($urandom_range(0, 40));

			// Fill the don't-care fields with noise so every bit toggles.
			r.entity_id   = $urandom();
			r.slot        = SLOT_W'($urandom());
			r.time_offset = OFS_W'($urandom());
			r.pop_timeout = OFS_W'($urandom());
			r.now         = clock_base;

			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				// reschedule, mostly within a small slot pool so entries relink
				r.req_type = REQ_RESET;
				while (r.entity_id == '0)
					r.entity_id = $urandom();
				if (pick < 45)
					r.slot = SLOT_W'($urandom_range(0, POOL_SLOTS - 1));
				sel = $urandom_range(0, 9);
				if (sel < 3)
					r.time_offset = '0;
				else if (sel < 9)
					r.time_offset = OFS_W'($urandom_range(1, 64));
			end else if (pick < 92) begin
				// pop, mostly with a short timeout, and a slightly later now
				r.req_type = REQ_POP;
				if ($urandom_range(0, 9) < 7)
					r.pop_timeout = OFS_W'($urandom_range(0, 32));
				r.now = clock_base + TIME_W'($urandom_range(0, 64));
			end else if ($urandom_range(0, 1) == 0) begin
				// ignored reschedule
				r.req_type = REQ_RESET;
				r.entity_id = '0;
				r.now = $urandom();
			end else begin
				// pop at an arbitrary time
				r.req_type = REQ_POP;
				r.now = $urandom();
			end

			gap = quiet ? 0 : $urandom_range(0, 13);
			issue_item(r, gap, 1'b0, '0);
			if (!(r.req_type == REQ_RESET && r.entity_id == '0))
				counted++;
		end
		start <= 1'b0;

		// Drain, then idle a little longer to catch stray strobes.
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d reschedules, %0d pops (%0d expired), %0d ignored items",
			n_resched, n_pops, n_expired, n_ignored);
		$display("checked %0d results in %0d cycles, %0d mismatches",
			results_seen, cycle_count, mismatches);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/sto_pkg.sv
hw/rtl/sto_mem.sv
hw/rtl/sto_ctrl.sv
hw/rtl/sorted_timeout_list_top.sv
tb/sv/sorted_timeout_list_top_tb.sv
